### rtl/gba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gba_pkg
// Shared types and constants for the group-by integer aggregator.
// ----------------------------------------------------------------------------
package gba_pkg;

   localparam int unsigned TableDepthMax = 64;
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = 3;

   // operation codes
   localparam logic [2:0] OP_MIN   = 3'd0;
   localparam logic [2:0] OP_MAX   = 3'd1;
   localparam logic [2:0] OP_SUM   = 3'd2;
   localparam logic [2:0] OP_AVG   = 3'd3;
   localparam logic [2:0] OP_COUNT = 3'd4;

   // item modes
   localparam logic [1:0] MODE_MERGE = 2'd0;
   localparam logic [1:0] MODE_EMIT  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_AGGREGATE_OP = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_GROUPING_ON  = 1'd1;

   typedef struct packed {
      logic [1:0]         mode;
      logic [31:0]        group_key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0]        out_key;
      logic signed [31:0] out_value;
      logic               is_last;
      logic               no_groups;
      logic               overflowed;
   } rsp_type;

   // one-bit-per-cycle divider handshake
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

endpackage

### rtl/gba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gba_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module gba_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

### rtl/gba_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gba_div
// Signed 32-bit by unsigned 32-bit divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module gba_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  dividend,
   input  logic [31:0]         divisor,
   output gba_pkg::div_ctl_type ctl,
   output logic signed [31:0]  quotient
);
   import gba_pkg::*;

   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] mag;

   assign mag   = dividend[31] ? (~dividend + 32'd1) : dividend;
   assign trial = {rem_ff[31:0], quo_ff[31]} - {1'b0, den_ff};

   // restoring step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = mag;
         rem_in  = '0;
         den_in  = divisor;
         neg_in  = dividend[31];
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign quotient  = neg_ff ? (~quo_ff + 32'd1) : quo_ff;
   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
endmodule

### rtl/group_by_integer_aggregate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_by_integer_aggregate
// Group-by aggregator: merge, emit and clear items over a keyed table.
//
//   channel  ports                         handshake
//   req      req_start/req_busy/req_data   accepted when start & !busy
//   rsp      rsp_strobe/rsp_data           one-cycle strobe per item, no stall
//   csr      csr_wr_en/csr_index/csr_data  written on any edge with wr_en
//
// Merge: a key search reads one entry at a time through the RAM port (read
// state, then check state), then writes or drops. Emit: read, check, a
// divide for averages, and output per group. Clear: resets groups_used in
// idle. Reset is synchronous; the table needs no clearing pass since only
// entries below groups_used are read. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module group_by_integer_aggregate #(
   parameter int unsigned TABLE_DEPTH = gba_pkg::TableDepthMax
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_start,
   output logic                                req_busy,
   input  gba_pkg::req_type                    req_data,
   output logic                                rsp_strobe,
   output gba_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [gba_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [gba_pkg::CsrDataWidth-1:0]    csr_data
);
   import gba_pkg::*;

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_M_READ, ST_M_CHECK, ST_M_WRITE,
      ST_E_READ, ST_E_CHECK, ST_E_DIV, ST_E_OUT
   } state_type;

   state_type       state_ff;
   logic [2:0]      op_ff;
   logic            grp_ff;
   logic [CW-1:0]   used_ff;
   logic            ovf_ff;
   logic [CW-1:0]   idx_ff;
   logic [31:0]     key_ff;
   logic [31:0]     val_ff;
   logic [31:0]     res_ff;
   logic            rsp_strobe_ff;
   rsp_type         rsp_data_ff;

   // shared table port
   logic [AW-1:0]   addr;
   logic            wr_en;
   logic [95:0]     wr_word, rd_word;
   logic [31:0]     rd_key, rd_agg, rd_cnt;
   logic [31:0]     new_agg;
   logic            div_start;
   div_ctl_type     div_ctl;
   logic [31:0]     div_q;

   assign rd_key = rd_word[95:64];
   assign rd_agg = rd_word[63:32];
   assign rd_cnt = rd_word[31:0];
   assign addr   = idx_ff[AW-1:0];

   gba_ram #(.WIDTH(96), .DEPTH(TABLE_DEPTH)) u_table (
      .clock(clock), .wr_en(wr_en), .addr(addr),
      .wr_data(wr_word), .rd_data(rd_word)
   );

   gba_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(rd_agg), .divisor(rd_cnt), .ctl(div_ctl), .quotient(div_q)
   );

   // fold of the value into an existing entry
   always_comb begin
      unique case (op_ff)
         OP_MIN:  new_agg = ($signed(val_ff) < $signed(rd_agg)) ? val_ff : rd_agg;
         OP_MAX:  new_agg = ($signed(val_ff) > $signed(rd_agg)) ? val_ff : rd_agg;
         default: new_agg = rd_agg + val_ff;
      endcase
   end

   assign wr_en = (state_ff == ST_M_WRITE);
   assign wr_word = (idx_ff == used_ff) ? {key_ff, val_ff, 32'd1}
                                        : {key_ff, new_agg, rd_cnt + 32'd1};
   assign div_start = (state_ff == ST_E_CHECK) && (op_ff == OP_AVG)
                      && (rd_cnt != 32'd0);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_MIN;
         grp_ff        <= 1'b1;
         used_ff       <= '0;
         ovf_ff        <= 1'b0;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_wr_en) begin
            if (csr_index == CSR_AGGREGATE_OP) op_ff <= csr_data;
            if (csr_index == CSR_GROUPING_ON)  grp_ff <= csr_data[0];
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_start) begin
                  key_ff <= grp_ff ? req_data.group_key : 32'd0;
                  val_ff <= req_data.value;
                  idx_ff <= '0;
                  if (req_data.mode == MODE_MERGE) begin
                     state_ff <= ST_M_READ;
                  end else if (req_data.mode == MODE_CLEAR) begin
                     used_ff <= '0;
                  end else if (req_data.mode == MODE_EMIT) begin
                     if (used_ff == '0) begin
                        rsp_strobe_ff <= 1'b1;
                        rsp_data_ff   <= '{out_key: '0, out_value: '0, is_last: 1'b1,
                                           no_groups: 1'b1, overflowed: ovf_ff};
                     end else begin
                        state_ff <= ST_E_READ;
                     end
                  end
               end
            end
            ST_M_READ: begin
               // search past the end: allocate or drop
               if (idx_ff == used_ff) begin
                  if (used_ff == CW'(TABLE_DEPTH)) begin
                     ovf_ff   <= 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_M_WRITE;
                  end
               end else begin
                  state_ff <= ST_M_CHECK;
               end
            end
            ST_M_CHECK: begin
               if (rd_key == key_ff) begin
                  state_ff <= ST_M_WRITE;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= ST_M_READ;
               end
            end
            ST_M_WRITE: begin
               if (idx_ff == used_ff) used_ff <= used_ff + CW'(1);
               state_ff <= ST_IDLE;
            end
            ST_E_READ: begin
               state_ff <= ST_E_CHECK;
            end
            ST_E_CHECK: begin
               if (op_ff == OP_COUNT) res_ff <= rd_cnt;
               else if (op_ff == OP_AVG) res_ff <= 32'd0;
               else res_ff <= rd_agg;
               state_ff <= div_start ? ST_E_DIV : ST_E_OUT;
            end
            ST_E_DIV: begin
               if (div_ctl.done) begin
                  res_ff   <= div_q;
                  state_ff <= ST_E_OUT;
               end
            end
            ST_E_OUT: begin
               rsp_strobe_ff <= 1'b1;
               rsp_data_ff   <= '{out_key: grp_ff ? rd_key : 32'd0, out_value: res_ff,
                                  is_last: (idx_ff + CW'(1) == used_ff),
                                  no_groups: 1'b0, overflowed: ovf_ff};
               if (idx_ff + CW'(1) == used_ff) begin
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= ST_E_READ;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_busy   = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // assertions
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(TABLE_DEPTH)) else $error("groups_used beyond table");
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(ovf_ff) && !$past(reset) |-> ovf_ff) else $error("overflow flag cleared");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctl.busy |-> state_ff == ST_E_DIV) else $error("divider busy outside divide");
endmodule
